// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; clk and arst_n are taken from the
// scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/rres_pkg.sv
// ----------------------------------------------------------------------------
// rres_pkg
// Types, codes and fixed-point helpers of the rigid rotor Euler step block.
// ----------------------------------------------------------------------------
package rres_pkg;

	localparam int MAX_NODES_DEF    = 64;
	localparam int CORDIC_STEPS_DEF = 24;

	// node numbers and counts up to the largest vertex store
	localparam int NODE_W = 8;
	localparam int STEP_W = 5;
	localparam int LIMB_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_FORCE   = 2'd1;
	localparam logic [1:0] MODE_SAVE    = 2'd2;
	localparam logic [1:0] MODE_RESTORE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_INV_INERTIA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd1;

	localparam logic signed [33:0] GAIN_Q30    = 34'sh026DD3B6A;
	localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
	localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
	localparam logic [LIMB_W-1:0]  LIMB_LAST   = 3'd4;

	// datapath operations
	typedef logic [4:0] op_t;
	localparam op_t OP_NOP     = 5'd0;
	localparam op_t OP_LATCH   = 5'd1;
	localparam op_t OP_LOAD    = 5'd2;
	localparam op_t OP_SAVE    = 5'd3;
	localparam op_t OP_RESTORE = 5'd4;
	localparam op_t OP_RD      = 5'd5;
	localparam op_t OP_RX0     = 5'd6;
	localparam op_t OP_RX1     = 5'd7;
	localparam op_t OP_RY0     = 5'd8;
	localparam op_t OP_RY1     = 5'd9;
	localparam op_t OP_RFIN    = 5'd10;
	localparam op_t OP_P1      = 5'd11;
	localparam op_t OP_P2      = 5'd12;
	localparam op_t OP_MOM     = 5'd13;
	localparam op_t OP_MAG     = 5'd14;
	localparam op_t OP_LMUL    = 5'd15;
	localparam op_t OP_LACC    = 5'd16;
	localparam op_t OP_RATE    = 5'd17;
	localparam op_t OP_AMUL    = 5'd18;
	localparam op_t OP_ANG     = 5'd19;
	localparam op_t OP_CINIT   = 5'd20;
	localparam op_t OP_CRED    = 5'd21;
	localparam op_t OP_CSTART  = 5'd22;
	localparam op_t OP_CITER   = 5'd23;
	localparam op_t OP_CFIN    = 5'd24;
	localparam op_t OP_OUT     = 5'd25;

	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  node_index;
		logic [31:0] coord_x;
		logic [31:0] coord_y;
		logic [31:0] force_x;
		logic [31:0] force_y;
		logic        last_force;
		logic [31:0] time_step;
	} in_item_t;

	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] addr;
		logic [LIMB_W-1:0] limb;
		logic              pass;
		logic [STEP_W-1:0] step;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic              last;
		logic [NODE_W-1:0] idx;
		logic              idx_in_use;
		logic              red_done;
		logic [NODE_W-1:0] n_m1;
	} stat_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  return 32'h3243F6A8;
			5'd1:  return 32'h1DAC6705;
			5'd2:  return 32'h0FADBAFC;
			5'd3:  return 32'h07F56EA6;
			5'd4:  return 32'h03FEAB76;
			5'd5:  return 32'h01FFD55B;
			5'd6:  return 32'h00FFFAAA;
			5'd7:  return 32'h007FFF55;
			5'd8:  return 32'h003FFFEA;
			5'd9:  return 32'h001FFFFD;
			5'd10: return 32'h000FFFFF;
			5'd11: return 32'h0007FFFF;
			5'd12: return 32'h0003FFFF;
			5'd13: return 32'h0001FFFF;
			5'd14: return 32'h0000FFFF;
			5'd15: return 32'h00007FFF;
			5'd16: return 32'h00003FFF;
			5'd17: return 32'h00001FFF;
			5'd18: return 32'h00000FFF;
			5'd19: return 32'h000007FF;
			5'd20: return 32'h000003FF;
			5'd21: return 32'h000001FF;
			5'd22: return 32'h000000FF;
			5'd23: return 32'h0000007F;
			5'd24: return 32'h0000003F;
			5'd25: return 32'h0000001F;
			5'd26: return 32'h0000000F;
			5'd27: return 32'h00000008;
			5'd28: return 32'h00000004;
			5'd29: return 32'h00000002;
			5'd30: return 32'h00000001;
			default: return 32'h00000000;
		endcase
	endfunction

	function automatic logic [31:0] sat32(input logic signed [66:0] v);
		if (v[66:31] == '0 || v[66:31] == '1)
			return v[31:0];
		return v[66] ? 32'h80000000 : 32'h7FFFFFFF;
	endfunction

	function automatic logic [63:0] sat64(input logic signed [66:0] v);
		if (v[66:63] == '0 || v[66:63] == '1)
			return v[63:0];
		return v[66] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
	endfunction

	// (v + 2^29) >> 30, floor, then saturate
	function automatic logic [31:0] round_sat(input logic signed [66:0] v);
		logic signed [66:0] t;
		t = (v + 67'sd536870912) >>> 30;
		return sat32(t);
	endfunction

endpackage

// File: hw/rtl/rres_in_if.sv
// ----------------------------------------------------------------------------
// rres_in_if
// Input channel: valid/ready handshake carrying one input item per beat.
// ----------------------------------------------------------------------------
interface rres_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [5:0]  node_index;
	logic [31:0] coord_x;
	logic [31:0] coord_y;
	logic [31:0] force_x;
	logic [31:0] force_y;
	logic        last_force;
	logic [31:0] time_step;

	modport source (output valid, mode, node_index, coord_x, coord_y, force_x, force_y,
		last_force, time_step, input ready);
	modport sink (input valid, mode, node_index, coord_x, coord_y, force_x, force_y,
		last_force, time_step, output ready);
endinterface

// File: hw/rtl/rres_out_if.sv
// ----------------------------------------------------------------------------
// rres_out_if
// Output channel: valid/ready handshake carrying one rotated vertex per beat.
// ----------------------------------------------------------------------------
interface rres_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  out_index;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] angle_out;
	logic [31:0] rate_out;
	logic        last_node;

	modport source (output valid, out_index, pos_x, pos_y, angle_out, rate_out, last_node,
		input ready);
	modport sink (input valid, out_index, pos_x, pos_y, angle_out, rate_out, last_node,
		output ready);
endinterface

// File: hw/rtl/rigid_rotor_euler_step_top.sv
// ----------------------------------------------------------------------------
// rigid_rotor_euler_step_top
// Planar rigid rotor, forward Euler step with CORDIC vertex rotation.
// ----------------------------------------------------------------------------
// One item is in work at a time; ready is high only while the block is idle.
// Vertex load writes the store and save copies angle and rate; restore copies
// them back, reduces the angle and runs the CORDIC. A force sample on a vertex
// in use rotates it and adds its moment (nothing if the vertex is not in use).
// The last force adds the moment, rate and angle update, the CORDIC as for
// restore, and emits every vertex, waiting while the sink stalls. The single
// shared 33x33 multiplier serves them all: every product of rotation, moment and step goes through it.
module rigid_rotor_euler_step_top import rres_pkg::*; #(
	parameter int MAX_NODES    = MAX_NODES_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	rres_in_if.sink              in_ch,
	rres_out_if.source           out_ch
);

	`include "assert_macros.svh"

	cmd_t     cmd;
	stat_t    stat;
	in_item_t in_item;

	assign in_item.mode       = in_ch.mode;
	assign in_item.node_index = in_ch.node_index;
	assign in_item.coord_x    = in_ch.coord_x;
	assign in_item.coord_y    = in_ch.coord_y;
	assign in_item.force_x    = in_ch.force_x;
	assign in_item.force_y    = in_ch.force_y;
	assign in_item.last_force = in_ch.last_force;
	assign in_item.time_step  = in_ch.time_step;

	rres_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rres_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.o_index   (out_ch.out_index),
		.o_pos_x   (out_ch.pos_x),
		.o_pos_y   (out_ch.pos_y),
		.o_angle   (out_ch.angle_out),
		.o_rate    (out_ch.rate_out),
		.o_last    (out_ch.last_node)
	);

	`ASSERT_IMP(a_no_overwrite, cmd.op == OP_OUT, !out_ch.valid || out_ch.ready, "output beat overwritten while stalled")
	`ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "ready held after accept")
	`ASSERT_IMP(a_last_index, out_ch.valid && out_ch.last_node, out_ch.out_index == stat.n_m1[5:0], "last beat on wrong vertex")

endmodule

// File: hw/rtl/rres_ram.sv
// ----------------------------------------------------------------------------
// rres_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rres_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/rres_datapath.sv
// ----------------------------------------------------------------------------
// rres_datapath
// Vertex store, shared 33x33 multiplier, moment and step arithmetic, CORDIC.
// ----------------------------------------------------------------------------
module rres_datapath import rres_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  in_item_t             in_item,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output logic [5:0]           o_index,
	output logic [31:0]          o_pos_x,
	output logic [31:0]          o_pos_y,
	output logic [31:0]          o_angle,
	output logic [31:0]          o_rate,
	output logic                 o_last
);

	in_item_t in_q;
	logic [31:0] inv_q;
	logic [6:0]  ncnt_q;

	logic signed [31:0] angle_q, rate_q, cos_q, sin_q, sv_angle_q, sv_rate_q;
	logic signed [63:0] moment_q;

	logic signed [65:0] prod_q, acc_q;
	logic [31:0] w_q [5];
	logic [31:0] carry_q;
	logic [31:0] px_q, py_q;
	logic signed [33:0] ca_q, cx_q, cy_q, cz_q;
	logic flip_q;

	// ---------------- vertex store ----------------
	logic [63:0] ram_rd;
	logic signed [31:0] x0, y0;

	rres_ram #(.WIDTH(64), .DEPTH(MAX_NODES)) u_ram (
		.clk   (clk),
		.we    (cmd.op == OP_LOAD && in_q.node_index < 9'(MAX_NODES)),
		.waddr (AW'(in_q.node_index)),
		.wdata ({in_q.coord_x, in_q.coord_y}),
		.re    (cmd.op == OP_RD),
		.raddr (cmd.addr[AW-1:0]),
		.rdata (ram_rd)
	);

	assign x0 = ram_rd[63:32];
	assign y0 = ram_rd[31:0];

	// ---------------- status ----------------
	logic [NODE_W-1:0] n_act;

	always_comb begin
		if (ncnt_q == 7'd0)
			n_act = NODE_W'(1);
		else if (9'(ncnt_q) > 9'(MAX_NODES))
			n_act = NODE_W'(MAX_NODES);
		else
			n_act = NODE_W'(ncnt_q);
	end

	assign stat.mode       = in_q.mode;
	assign stat.last       = in_q.last_force;
	assign stat.idx        = NODE_W'(in_q.node_index);
	assign stat.idx_in_use = NODE_W'(in_q.node_index) < n_act;
	assign stat.red_done   = !(ca_q > HALF_PI_Q28) && !(ca_q < -HALF_PI_Q28);
	assign stat.n_m1       = n_act - NODE_W'(1);

	// ---------------- shared multiplier ----------------
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_w;
	logic [31:0] rmag;
	logic [31:0] lf;

	assign rmag = rate_q[31] ? (~rate_q + 32'd1) : rate_q;
	assign lf   = cmd.pass ? inv_q : in_q.time_step;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_RX0: begin mul_a = 33'(x0); mul_b = 33'(cos_q); end
			OP_RX1: begin mul_a = 33'(y0); mul_b = 33'(sin_q); end
			OP_RY0: begin mul_a = 33'(y0); mul_b = 33'(cos_q); end
			OP_RY1: begin mul_a = 33'(x0); mul_b = 33'(sin_q); end
			OP_P1:  begin
				mul_a = 33'(signed'(px_q));
				mul_b = 33'(signed'(in_q.force_y));
			end
			OP_P2:  begin
				mul_a = 33'(signed'(py_q));
				mul_b = 33'(signed'(in_q.force_x));
			end
			OP_LMUL: begin mul_a = {1'b0, w_q[cmd.limb]}; mul_b = {1'b0, lf}; end
			OP_AMUL: begin mul_a = {1'b0, rmag}; mul_b = {1'b0, in_q.time_step}; end
			default: ;
		endcase
	end

	assign prod_w = mul_a * mul_b;

	// ---------------- combinational results ----------------
	logic signed [66:0] rsum, rdif, mdif, madd;
	logic [63:0] diff64, mag;
	logic [63:0] lsum;
	logic        ovf, neg;
	logic [31:0] inc, nr;
	logic signed [66:0] rate_sum, ang_sum;
	logic [43:0] dang;
	logic signed [33:0] dx, dy, at;

	assign rsum   = 67'(acc_q) + 67'(prod_q);
	assign rdif   = 67'(acc_q) - 67'(prod_q);
	assign mdif   = 67'(acc_q) - 67'(prod_q);
	assign diff64 = sat64(mdif);
	assign madd   = 67'(moment_q) + 67'(signed'(diff64));
	assign mag    = moment_q[63] ? (64'd0 - moment_q) : moment_q;
	assign lsum   = prod_q[63:0] + ((cmd.limb == '0) ? 64'd0 : 64'(carry_q));

	assign neg  = moment_q[63];
	assign ovf  = (w_q[2][31:24] != 8'd0) || (w_q[3] != 32'd0) || (w_q[4] != 32'd0);
	assign inc  = {w_q[2][23:0], w_q[1][31:24]};
	assign rate_sum = neg ? (67'(rate_q) - 67'(inc)) : (67'(rate_q) + 67'(inc));
	assign nr   = ovf ? (neg ? 32'h80000000 : 32'h7FFFFFFF) : sat32(rate_sum);

	assign dang    = prod_q[63:20];
	assign ang_sum = rate_q[31] ? (67'(angle_q) - 67'(dang)) : (67'(angle_q) + 67'(dang));

	assign dx = cy_q >>> cmd.step;
	assign dy = cx_q >>> cmd.step;
	assign at = 34'(signed'(atan_q30(cmd.step)));

	// ---------------- architectural state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q      <= '0;
			ncnt_q     <= 7'd36;
			angle_q    <= '0;
			rate_q     <= '0;
			cos_q      <= 32'sh40000000;
			sin_q      <= '0;
			moment_q   <= '0;
			sv_angle_q <= '0;
			sv_rate_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INV_INERTIA: inv_q <= cfg_data;
					CFG_NODE_COUNT:  ncnt_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_SAVE: begin
					sv_angle_q <= angle_q;
					sv_rate_q  <= rate_q;
				end
				OP_RESTORE: begin
					angle_q <= sv_angle_q;
					rate_q  <= sv_rate_q;
				end
				OP_MOM:  moment_q <= sat64(madd);
				OP_RATE: rate_q <= nr;
				OP_ANG: begin
					angle_q  <= sat32(ang_sum);
					moment_q <= '0;
				end
				OP_CFIN: begin
					cos_q <= sat32(67'(flip_q ? -cx_q : cx_q));
					sin_q <= sat32(67'(flip_q ? -cy_q : cy_q));
				end
				default: ;
			endcase
		end
	end

	// ---------------- working registers ----------------
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: in_q <= in_item;
			OP_RX0, OP_RY0, OP_P1, OP_LMUL, OP_AMUL: prod_q <= prod_w;
			OP_RX1, OP_RY1, OP_P2: begin
				acc_q  <= prod_q;
				prod_q <= prod_w;
			end
			default: ;
		endcase
		if (cmd.op == OP_RY0)
			px_q <= round_sat(rsum);
		if (cmd.op == OP_RFIN)
			py_q <= round_sat(rdif);
		if (cmd.op == OP_MAG) begin
			w_q[0] <= mag[31:0];
			w_q[1] <= mag[63:32];
			w_q[2] <= '0;
			w_q[3] <= '0;
			w_q[4] <= '0;
		end
		if (cmd.op == OP_LACC) begin
			w_q[cmd.limb] <= lsum[31:0];
			carry_q       <= lsum[63:32];
		end
		case (cmd.op)
			OP_CINIT: begin
				ca_q   <= 34'(angle_q);
				flip_q <= 1'b0;
			end
			OP_CRED: begin
				if (ca_q > HALF_PI_Q28) begin
					ca_q   <= ca_q - PI_Q28;
					flip_q <= !flip_q;
				end else if (ca_q < -HALF_PI_Q28) begin
					ca_q   <= ca_q + PI_Q28;
					flip_q <= !flip_q;
				end
			end
			OP_CSTART: begin
				cz_q <= ca_q <<< 2;
				cx_q <= GAIN_Q30;
				cy_q <= '0;
			end
			OP_CITER: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + at;
				end
			end
			default: ;
		endcase
		if (cmd.op == OP_OUT) begin
			o_index <= cmd.addr[5:0];
			o_pos_x <= px_q;
			o_pos_y <= py_q;
			o_angle <= angle_q;
			o_rate  <= rate_q;
			o_last  <= cmd.last;
		end
	end

endmodule

// File: hw/rtl/rres_ctrl.sv
// ----------------------------------------------------------------------------
// rres_ctrl
// Sequencer: dispatches items, steps the datapath and drives the handshakes.
// ----------------------------------------------------------------------------
module rres_ctrl import rres_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_RD     = 5'd2;
	localparam logic [4:0] S_RX0    = 5'd3;
	localparam logic [4:0] S_RX1    = 5'd4;
	localparam logic [4:0] S_RY0    = 5'd5;
	localparam logic [4:0] S_RY1    = 5'd6;
	localparam logic [4:0] S_RFIN   = 5'd7;
	localparam logic [4:0] S_P1     = 5'd8;
	localparam logic [4:0] S_P2     = 5'd9;
	localparam logic [4:0] S_MOM    = 5'd10;
	localparam logic [4:0] S_MAG    = 5'd11;
	localparam logic [4:0] S_LMUL   = 5'd12;
	localparam logic [4:0] S_LACC   = 5'd13;
	localparam logic [4:0] S_RATE   = 5'd14;
	localparam logic [4:0] S_AMUL   = 5'd15;
	localparam logic [4:0] S_ANG    = 5'd16;
	localparam logic [4:0] S_CINIT  = 5'd17;
	localparam logic [4:0] S_CRED   = 5'd18;
	localparam logic [4:0] S_CSTART = 5'd19;
	localparam logic [4:0] S_CITER  = 5'd20;
	localparam logic [4:0] S_CFIN   = 5'd21;
	localparam logic [4:0] S_OUT    = 5'd22;

	logic [4:0] state_q, state_d;
	logic [NODE_W-1:0] k_q, k_d;
	logic [LIMB_W-1:0] limb_q, limb_d;
	logic pass_q, pass_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic run_q, run_d;
	logic emit_q, emit_d;
	logic ovalid_q;
	logic out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;
	assign out_free  = !ovalid_q || out_ready;

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		limb_d  = limb_q;
		pass_d  = pass_q;
		step_d  = step_q;
		run_d   = run_q;
		emit_d  = emit_q;
		cmd     = '0;
		cmd.limb = limb_q;
		cmd.pass = pass_q;
		cmd.step = step_q;
		cmd.addr = emit_q ? k_q : stat.idx;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				run_d  = 1'b0;
				emit_d = 1'b0;
				unique case (stat.mode)
					MODE_LOAD: begin
						cmd.op  = OP_LOAD;
						state_d = S_IDLE;
					end
					MODE_SAVE: begin
						cmd.op  = OP_SAVE;
						state_d = S_IDLE;
					end
					MODE_RESTORE: begin
						cmd.op  = OP_RESTORE;
						state_d = S_CINIT;
					end
					MODE_FORCE: begin
						if (stat.idx_in_use)
							state_d = S_RD;
						else if (stat.last)
							state_d = S_MAG;
						else
							state_d = S_IDLE;
					end
				endcase
			end
			S_RD: begin
				cmd.op  = OP_RD;
				state_d = S_RX0;
			end
			S_RX0: begin
				cmd.op  = OP_RX0;
				state_d = S_RX1;
			end
			S_RX1: begin
				cmd.op  = OP_RX1;
				state_d = S_RY0;
			end
			S_RY0: begin
				cmd.op  = OP_RY0;
				state_d = S_RY1;
			end
			S_RY1: begin
				cmd.op  = OP_RY1;
				state_d = S_RFIN;
			end
			S_RFIN: begin
				cmd.op  = OP_RFIN;
				state_d = emit_q ? S_OUT : S_P1;
			end
			S_P1: begin
				cmd.op  = OP_P1;
				state_d = S_P2;
			end
			S_P2: begin
				cmd.op  = OP_P2;
				state_d = S_MOM;
			end
			S_MOM: begin
				cmd.op  = OP_MOM;
				state_d = stat.last ? S_MAG : S_IDLE;
			end
			S_MAG: begin
				cmd.op  = OP_MAG;
				run_d   = 1'b1;
				limb_d  = '0;
				pass_d  = 1'b0;
				state_d = S_LMUL;
			end
			S_LMUL: begin
				cmd.op  = OP_LMUL;
				state_d = S_LACC;
			end
			S_LACC: begin
				cmd.op = OP_LACC;
				if (limb_q == LIMB_LAST) begin
					limb_d = '0;
					pass_d = 1'b1;
					state_d = pass_q ? S_RATE : S_LMUL;
				end else begin
					limb_d  = limb_q + LIMB_W'(1);
					state_d = S_LMUL;
				end
			end
			S_RATE: begin
				cmd.op  = OP_RATE;
				state_d = S_AMUL;
			end
			S_AMUL: begin
				cmd.op  = OP_AMUL;
				state_d = S_ANG;
			end
			S_ANG: begin
				cmd.op  = OP_ANG;
				state_d = S_CINIT;
			end
			S_CINIT: begin
				cmd.op  = OP_CINIT;
				state_d = S_CRED;
			end
			S_CRED: begin
				// one step of pi per cycle until the angle is in range
				cmd.op  = OP_CRED;
				state_d = stat.red_done ? S_CSTART : S_CRED;
			end
			S_CSTART: begin
				cmd.op  = OP_CSTART;
				step_d  = '0;
				state_d = S_CITER;
			end
			S_CITER: begin
				cmd.op = OP_CITER;
				if (step_q == STEP_LAST) begin
					state_d = S_CFIN;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			S_CFIN: begin
				cmd.op = OP_CFIN;
				if (run_q) begin
					emit_d  = 1'b1;
					k_d     = '0;
					state_d = S_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_OUT: begin
				// next vertex computes while the previous beat still waits
				if (out_free) begin
					cmd.op   = OP_OUT;
					cmd.addr = k_q;
					cmd.last = (k_q == stat.n_m1);
					if (k_q == stat.n_m1) begin
						state_d = S_IDLE;
					end else begin
						k_d     = k_q + NODE_W'(1);
						state_d = S_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			k_q      <= '0;
			limb_q   <= '0;
			pass_q   <= 1'b0;
			step_q   <= '0;
			run_q    <= 1'b0;
			emit_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			limb_q  <= limb_d;
			pass_q  <= pass_d;
			step_q  <= step_d;
			run_q   <= run_d;
			emit_q  <= emit_d;
			if (cmd.op == OP_OUT)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

endmodule
